>>> hw/rtl/bmc_pkg.sv
// Shared constants and types for the bright marker centroid unit.
`default_nettype none
package bmc_pkg;

  localparam int MaxWidth  = 512;
  localparam int MaxHeight = 512;

  localparam int ColW   = $clog2(MaxWidth);
  localparam int RowW   = $clog2(MaxHeight);
  localparam int CntW   = 19;
  localparam int SumW   = 2 * ColW + RowW;
  // wide enough for the centroid numerator and for the 30-bit lateral and confidence products
  localparam int DivW   = (SumW + 5 > 32) ? SumW + 5 : 32;
  localparam int DivCntW = $clog2(DivW);
  localparam int FrameW = 10;
  localparam int CfgW   = 19;
  localparam int IdxW   = 3;

  localparam logic [CntW-1:0] TallyMax   = {CntW{1'b1}};
  localparam logic [12:0]     CentroidMax = 13'd8191;
  localparam logic [20:0]     LateralMax = 21'd1048575;
  localparam logic [15:0]     AltMin     = 16'd200;
  localparam logic [9:0]      ConfMax    = 10'd1000;
  localparam logic [9:0]      ConfMin    = 10'd100;

  typedef enum logic [IdxW-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_MIN_PIX   = 3'd1,
    REG_CENTER_U  = 3'd2,
    REG_CENTER_V  = 3'd3,
    REG_FOCAL     = 3'd4,
    REG_FULL_CONF = 3'd5,
    REG_WIDTH     = 3'd6,
    REG_HEIGHT    = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    JOB_CU,
    JOB_CV,
    JOB_LX,
    JOB_LY,
    JOB_CONF
  } job_e;

endpackage
`default_nettype wire

>>> hw/rtl/bright_marker_centroid_unit.sv
// Top level of the bright marker centroid unit: pixel accumulation and end-of-frame math.
`default_nettype none
// Usage:
//   Pixels enter in raster order on pixel_value_i with start_i; a word is taken at a
//   clock edge where start_i is high and busy_o is low. Column and row are counted
//   here from the frame_width and frame_height registers.
//   Ordinary pixels leave busy_o low, so pixels may stream, one per cycle.
//   The last pixel of a frame (with altitude_mm_i sampled there) raises busy_o and
//   starts the end-of-frame sequence: one restoring divider, one quotient bit per
//   cycle, shared by up to five divisions (two centroids, two lateral offsets,
//   confidence), plus a step on the shared multiplier (ST_MUL) before each of the
//   last three. The lateral divisions are skipped when the altitude is at most
//   200 mm; a frame with too few bright pixels goes from ST_CHECK straight to
//   ST_DONE.
//   The result is shown for one cycle with done_o high; the receiver cannot stall.
//   Configuration is written through wr_en_i / wr_idx_i / wr_data_i while idle; the block itself does not enforce this.
//   Reset loads the default registers, clears the counters and returns to idle.
module bright_marker_centroid_unit (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [7:0]               pixel_value_i,
  input  wire logic [15:0]              altitude_mm_i,
  input  wire logic                     wr_en_i,
  input  wire logic [bmc_pkg::IdxW-1:0] wr_idx_i,
  input  wire logic [bmc_pkg::CfgW-1:0] wr_data_i,
  output logic                          done_o,
  output logic                          detect_valid_o,
  output logic [18:0]                   bright_count_o,
  output logic [12:0]                   centroid_u_q4_o,
  output logic [12:0]                   centroid_v_q4_o,
  output logic signed [13:0]            offset_u_q4_o,
  output logic signed [13:0]            offset_v_q4_o,
  output logic signed [20:0]            lateral_x_mm_o,
  output logic signed [20:0]            lateral_y_mm_o,
  output logic [9:0]                    confidence_permille_o
);
  import bmc_pkg::*;

  // configuration registers
  logic [7:0]        thr_q;
  logic [CntW-1:0]   min_pix_q;
  logic [8:0]        center_u_q;
  logic [8:0]        center_v_q;
  logic [11:0]       focal_q;
  logic [CntW-1:0]   full_q;
  logic [FrameW-1:0] width_q;
  logic [FrameW-1:0] height_q;

  // accumulation state
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [SumW-1:0] sum_col_q, sum_col_d;
  logic [SumW-1:0] sum_row_q, sum_row_d;
  logic [CntW-1:0] tally_q, tally_d;
  logic [15:0]     alt_q;

  // sequencer and shared units
  state_e state_q, state_d;
  job_e   job_q, job_d;
  logic   valid_q, valid_d;

  logic [DivW-1:0]    quo_q;
  logic [CntW:0]      rem_q;
  logic [CntW-1:0]    dvs_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [DivW-1:0]    prod_q;

  logic [12:0] cu_q, cv_q;
  logic signed [20:0] lx_q, ly_q;
  logic [9:0]  conf_q;

  // effective configuration
  logic [FrameW-1:0] w_eff, h_eff;
  logic [CntW-1:0]   min_eff, full_eff;
  logic [11:0]       focal_eff;

  assign w_eff = (width_q == '0) ? FrameW'(1) :
                 (32'(width_q) > MaxWidth) ? FrameW'(MaxWidth) : width_q;
  assign h_eff = (height_q == '0) ? FrameW'(1) :
                 (32'(height_q) > MaxHeight) ? FrameW'(MaxHeight) : height_q;
  assign min_eff   = (min_pix_q == '0) ? CntW'(1) : min_pix_q;
  assign full_eff  = (full_q == '0) ? CntW'(1) : full_q;
  assign focal_eff = (focal_q == '0) ? 12'd1 : focal_q;

  // pixel path
  logic accept, first_pix, bright, last_col, last_row, last_pix;
  logic [CntW-1:0] tally_base;
  logic [SumW-1:0] sum_col_base, sum_row_base;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign first_pix = (col_q == '0) && (row_q == '0);
  assign bright    = pixel_value_i >= thr_q;
  assign last_col  = (32'(col_q) + 32'd1) >= 32'(w_eff);
  assign last_row  = (32'(row_q) + 32'd1) >= 32'(h_eff);
  assign last_pix  = last_col && last_row;

  always_comb begin
    tally_base   = first_pix ? '0 : tally_q;
    sum_col_base = first_pix ? '0 : sum_col_q;
    sum_row_base = first_pix ? '0 : sum_row_q;
    tally_d   = tally_base;
    sum_col_d = sum_col_base;
    sum_row_d = sum_row_base;
    if (bright) begin
      if (tally_base != TallyMax) tally_d = tally_base + CntW'(1);
      sum_col_d = sum_col_base + SumW'(col_q);
      sum_row_d = sum_row_base + SumW'(row_q);
    end
    col_d = col_q + ColW'(1);
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + RowW'(1);
    end
  end

  // offsets from the optical centre; the difference always fits 14 bits
  logic signed [13:0] ou, ov;
  logic [13:0] ou_abs, ov_abs;

  assign ou = $signed({1'b0, cu_q}) - $signed({1'b0, center_u_q, 4'b0000});
  assign ov = $signed({1'b0, cv_q}) - $signed({1'b0, center_v_q, 4'b0000});
  assign ou_abs = ou[13] ? 14'(-ou) : 14'(ou);
  assign ov_abs = ov[13] ? 14'(-ov) : 14'(ov);

  // shared multiplier operands
  logic [CntW-1:0] mul_a;
  logic [15:0]     mul_b;
  logic [CntW+15:0] mul_p;

  always_comb begin
    case (job_q)
      JOB_LX: begin
        mul_a = CntW'(ou_abs);
        mul_b = alt_q;
      end
      JOB_LY: begin
        mul_a = CntW'(ov_abs);
        mul_b = alt_q;
      end
      default: begin
        mul_a = tally_q;
        mul_b = 16'd1000;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // divider operands
  logic [DivW-1:0] div_num;
  logic [CntW-1:0] div_den;

  always_comb begin
    case (job_q)
      JOB_CU: begin
        div_num = DivW'({sum_col_q, 4'b0000}) + DivW'(tally_q >> 1);
        div_den = tally_q;
      end
      JOB_CV: begin
        div_num = DivW'({sum_row_q, 4'b0000}) + DivW'(tally_q >> 1);
        div_den = tally_q;
      end
      JOB_LX, JOB_LY: begin
        div_num = prod_q + DivW'({focal_eff, 3'b000});
        div_den = CntW'({focal_eff, 4'b0000});
      end
      default: begin
        div_num = prod_q;
        div_den = full_eff;
      end
    endcase
  end

  // one restoring step
  logic [CntW:0]   trial;
  logic            trial_ge;
  logic [CntW:0]   rem_next;
  logic [DivW-1:0] quo_next;
  logic            div_last;

  assign trial    = {rem_q[CntW-1:0], quo_q[DivW-1]};
  assign trial_ge = trial >= {1'b0, dvs_q};
  assign rem_next = trial_ge ? trial - {1'b0, dvs_q} : trial;
  assign quo_next = {quo_q[DivW-2:0], trial_ge};
  assign div_last = div_cnt_q == DivCntW'(DivW - 1);

  // saturated forms of the final quotient
  logic [12:0]        q_cent;
  logic               lat_neg;
  logic [20:0]        lat_cap;
  logic [20:0]        q_lat;
  logic signed [20:0] q_lat_s;
  logic [9:0]         q_conf;

  always_comb begin
    q_cent  = (quo_next > DivW'(CentroidMax)) ? CentroidMax : quo_next[12:0];
    lat_neg = (job_q == JOB_LX) ? ou[13] : ov[13];
    // a negative magnitude may reach one step further than a positive one
    lat_cap = lat_neg ? LateralMax + 21'd1 : LateralMax;
    q_lat   = (quo_next > DivW'(lat_cap)) ? lat_cap : quo_next[20:0];
    q_lat_s = lat_neg ? -$signed(q_lat) : $signed(q_lat);
    if (quo_next > DivW'(ConfMax))      q_conf = ConfMax;
    else if (quo_next < DivW'(ConfMin)) q_conf = ConfMin;
    else                                q_conf = quo_next[9:0];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= JOB_CU;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      valid_q <= valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    valid_d = valid_q;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (accept && last_pix) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        job_d = JOB_CU;
        if (tally_q < min_eff) begin
          valid_d = 1'b0;
          state_d = ST_DONE;
        end else begin
          valid_d = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_MUL: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (div_last) begin
          case (job_q)
            JOB_CU: begin
              job_d   = JOB_CV;
              state_d = ST_LOAD;
            end
            JOB_CV: begin
              // skip the lateral terms at low altitude
              job_d   = (alt_q > AltMin) ? JOB_LX : JOB_CONF;
              state_d = ST_MUL;
            end
            JOB_LX: begin
              job_d   = JOB_LY;
              state_d = ST_MUL;
            end
            JOB_LY: begin
              job_d   = JOB_CONF;
              state_d = ST_MUL;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // configuration and accumulation registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= 8'd200;
      min_pix_q  <= CntW'(20);
      center_u_q <= 9'd160;
      center_v_q <= 9'd120;
      focal_q    <= 12'd410;
      full_q     <= CntW'(5000);
      width_q    <= FrameW'(320);
      height_q   <= FrameW'(240);
      col_q      <= '0;
      row_q      <= '0;
      sum_col_q  <= '0;
      sum_row_q  <= '0;
      tally_q    <= '0;
    end else begin
      if (wr_en_i) begin
        case (reg_idx_e'(wr_idx_i))
          REG_THRESHOLD: thr_q      <= wr_data_i[7:0];
          REG_MIN_PIX:   min_pix_q  <= wr_data_i[CntW-1:0];
          REG_CENTER_U:  center_u_q <= wr_data_i[8:0];
          REG_CENTER_V:  center_v_q <= wr_data_i[8:0];
          REG_FOCAL:     focal_q    <= wr_data_i[11:0];
          REG_FULL_CONF: full_q     <= wr_data_i[CntW-1:0];
          REG_WIDTH:     width_q    <= wr_data_i[FrameW-1:0];
          REG_HEIGHT:    height_q   <= wr_data_i[FrameW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        col_q     <= col_d;
        row_q     <= row_d;
        sum_col_q <= sum_col_d;
        sum_row_q <= sum_row_d;
        tally_q   <= tally_d;
      end
    end
  end

  // datapath of the end-of-frame sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (state_q == ST_LOAD) begin
      div_cnt_q <= '0;
    end else if (state_q == ST_DIV) begin
      div_cnt_q <= div_cnt_q + DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) alt_q <= altitude_mm_i;
    if (state_q == ST_MUL) prod_q <= DivW'(mul_p);
    if (state_q == ST_LOAD) begin
      quo_q <= div_num;
      rem_q <= '0;
      dvs_q <= div_den;
    end else if (state_q == ST_DIV) begin
      quo_q <= quo_next;
      rem_q <= rem_next;
    end
    if (state_q == ST_CHECK) begin
      // zero the lateral terms; they stay so at low altitude
      lx_q <= '0;
      ly_q <= '0;
    end
    if (state_q == ST_DIV && div_last) begin
      case (job_q)
        JOB_CU:  cu_q   <= q_cent;
        JOB_CV:  cv_q   <= q_cent;
        JOB_LX:  lx_q   <= q_lat_s;
        JOB_LY:  ly_q   <= q_lat_s;
        default: conf_q <= q_conf;
      endcase
    end
  end

  // result word; all but the valid flag and the bright count are masked when the detection is not valid
  assign detect_valid_o        = valid_q;
  assign bright_count_o        = tally_q;
  assign centroid_u_q4_o       = valid_q ? cu_q : '0;
  assign centroid_v_q4_o       = valid_q ? cv_q : '0;
  assign offset_u_q4_o         = valid_q ? ou : '0;
  assign offset_v_q4_o         = valid_q ? ov : '0;
  assign lateral_x_mm_o        = valid_q ? lx_q : '0;
  assign lateral_y_mm_o        = valid_q ? ly_q : '0;
  assign confidence_permille_o = valid_q ? conf_q : '0;

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Testbench for the bright marker centroid unit: directed and random frames, frame predictor.
module tb_top;
  import bmc_pkg::*;

  localparam int CycleLimit   = 2_000_000;
  localparam int SettleCycles = 200;
  localparam int RandomItems  = 1950;
  localparam int ReportLimit  = 10;
  localparam longint LatHi    = 1048575;
  localparam longint LatLo    = -1048576;
  localparam longint OffHi    = 8191;
  localparam longint OffLo    = -8192;
  localparam longint LatCap   = 2000000;

  typedef struct {
    logic               valid;
    logic [18:0]        count;
    logic [12:0]        cu;
    logic [12:0]        cv;
    logic signed [13:0] ou;
    logic signed [13:0] ov;
    logic signed [20:0] lx;
    logic signed [20:0] ly;
    logic [9:0]         conf;
  } frame_result_t;

  class centroid_scoreboard;
    logic [7:0]      threshold;
    logic [18:0]     min_pix;
    logic [8:0]      center_u;
    logic [8:0]      center_v;
    logic [11:0]     focal;
    logic [18:0]     full_pix;
    logic [9:0]      width;
    logic [9:0]      height;
    int unsigned     col;
    int unsigned     row;
    longint unsigned tally;
    longint unsigned sum_col;
    longint unsigned sum_row;
    frame_result_t   pending_frames[$];
    int              mismatches;

    function new();
      threshold  = 8'd200;
      min_pix    = 19'd20;
      center_u   = 9'd160;
      center_v   = 9'd120;
      focal      = 12'd410;
      full_pix   = 19'd5000;
      width      = 10'd320;
      height     = 10'd240;
      col        = 0;
      row        = 0;
      tally      = 0;
      sum_col    = 0;
      sum_row    = 0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [18:0] value);
      case (idx)
        REG_THRESHOLD: threshold = value[7:0];
        REG_MIN_PIX:   min_pix   = value;
        REG_CENTER_U:  center_u  = value[8:0];
        REG_CENTER_V:  center_v  = value[8:0];
        REG_FOCAL:     focal     = value[11:0];
        REG_FULL_CONF: full_pix  = value;
        REG_WIDTH:     width     = value[9:0];
        REG_HEIGHT:    height    = value[9:0];
        default: ;
      endcase
    endfunction

    // Zero acts as one, oversize acts as the maximum.
    function int unsigned clamp_size(logic [9:0] v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint q4_centroid(longint sum, longint n);
      longint q;
      q = (sum * 16 + n / 2) / n;
      return (q > 8191) ? 8191 : q;
    endfunction

    // Round to nearest, ties away from zero, then saturate.
    function longint lateral(longint off, longint alt);
      longint mag;
      longint den;
      longint q;
      mag = (off < 0 ? -off : off) * alt;
      den = (focal == 0) ? 16 : 16 * longint'(focal);
      q = (mag + den / 2) / den;
      if (q > LatCap) q = LatCap;
      if (off < 0) q = -q;
      return clip(q, LatLo, LatHi);
    endfunction

    function void note_pixel(logic [7:0] pix, logic [15:0] alt);
      int unsigned   w;
      int unsigned   h;
      longint        n;
      longint        minp;
      longint        cu;
      longint        cv;
      longint        ou;
      longint        ov;
      longint        lx;
      longint        ly;
      longint        full;
      longint        conf;
      frame_result_t r;
      w = clamp_size(width, MaxWidth);
      h = clamp_size(height, MaxHeight);
      if (col == 0 && row == 0) begin
        tally   = 0;
        sum_col = 0;
        sum_row = 0;
      end
      if (pix >= threshold) begin
        if (tally < TallyMax) tally++;
        sum_col += col;
        sum_row += row;
      end
      if (col + 1 < w) begin
        col++;
        return;
      end
      col = 0;
      if (row + 1 < h) begin
        row++;
        return;
      end
      row = 0;

      r = '{default: '0};
      n = longint'(tally);
      r.count = 19'(n);
      minp = (min_pix == 0) ? 1 : longint'(min_pix);
      if (n >= minp) begin
        cu = q4_centroid(longint'(sum_col), n);
        cv = q4_centroid(longint'(sum_row), n);
        ou = clip(cu - 16 * longint'(center_u), OffLo, OffHi);
        ov = clip(cv - 16 * longint'(center_v), OffLo, OffHi);
        lx = 0;
        ly = 0;
        if (alt > AltMin) begin
          lx = lateral(ou, longint'(alt));
          ly = lateral(ov, longint'(alt));
        end
        full = (full_pix == 0) ? 1 : longint'(full_pix);
        conf = n * 1000 / full;
        if (conf > 1000) conf = 1000;
        if (conf < 100) conf = 100;
        r.valid = 1'b1;
        r.cu    = 13'(cu);
        r.cv    = 13'(cv);
        r.ou    = 14'(ou);
        r.ov    = 14'(ov);
        r.lx    = 21'(lx);
        r.ly    = 21'(ly);
        r.conf  = 10'(conf);
      end
      pending_frames.push_back(r);
    endfunction

    function void check_frame(frame_result_t got);
      frame_result_t exp_r;
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected frame result: valid %0d count %0d", got.valid, got.count);
        return;
      end
      exp_r = pending_frames.pop_front();
      if (got.valid !== exp_r.valid || got.count !== exp_r.count ||
          got.cu !== exp_r.cu || got.cv !== exp_r.cv ||
          got.ou !== exp_r.ou || got.ov !== exp_r.ov ||
          got.lx !== exp_r.lx || got.ly !== exp_r.ly ||
          got.conf !== exp_r.conf) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("frame mismatch: expected valid %0d count %0d cu %0d cv %0d ou %0d ov %0d lx %0d ly %0d conf %0d",
                   exp_r.valid, exp_r.count, exp_r.cu, exp_r.cv, exp_r.ou, exp_r.ov,
                   exp_r.lx, exp_r.ly, exp_r.conf);
          $display("                actual   valid %0d count %0d cu %0d cv %0d ou %0d ov %0d lx %0d ly %0d conf %0d",
                   got.valid, got.count, got.cu, got.cv, got.ou, got.ov,
                   got.lx, got.ly, got.conf);
        end
      end
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              start_i       = 1'b0;
  logic [7:0]        pixel_value_i = '0;
  logic [15:0]       altitude_mm_i = '0;
  logic              wr_en_i       = 1'b0;
  logic [IdxW-1:0]   wr_idx_i      = '0;
  logic [CfgW-1:0]   wr_data_i     = '0;
  logic              busy_o;
  logic              done_o;
  logic              detect_valid_o;
  logic [18:0]       bright_count_o;
  logic [12:0]       centroid_u_q4_o;
  logic [12:0]       centroid_v_q4_o;
  logic signed [13:0] offset_u_q4_o;
  logic signed [13:0] offset_v_q4_o;
  logic signed [20:0] lateral_x_mm_o;
  logic signed [20:0] lateral_y_mm_o;
  logic [9:0]        confidence_permille_o;

  centroid_scoreboard sb;
  int                 idle_pct;
  int                 items_sent;
  int unsigned        cycles;

  bright_marker_centroid_unit u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start_i               (start_i),
    .busy_o                (busy_o),
    .pixel_value_i         (pixel_value_i),
    .altitude_mm_i         (altitude_mm_i),
    .wr_en_i               (wr_en_i),
    .wr_idx_i              (wr_idx_i),
    .wr_data_i             (wr_data_i),
    .done_o                (done_o),
    .detect_valid_o        (detect_valid_o),
    .bright_count_o        (bright_count_o),
    .centroid_u_q4_o       (centroid_u_q4_o),
    .centroid_v_q4_o       (centroid_v_q4_o),
    .offset_u_q4_o         (offset_u_q4_o),
    .offset_v_q4_o         (offset_v_q4_o),
    .lateral_x_mm_o        (lateral_x_mm_o),
    .lateral_y_mm_o        (lateral_y_mm_o),
    .confidence_permille_o (confidence_permille_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin : result_monitor
    frame_result_t got;
    if (rst_ni && done_o) begin
      got.valid = detect_valid_o;
      got.count = bright_count_o;
      got.cu    = centroid_u_q4_o;
      got.cv    = centroid_v_q4_o;
      got.ou    = offset_u_q4_o;
      got.ov    = offset_v_q4_o;
      got.lx    = lateral_x_mm_o;
      got.ly    = lateral_y_mm_o;
      got.conf  = confidence_permille_o;
      sb.check_frame(got);
    end
  end

  function automatic int pick_edge(int maxv);
    case ($urandom_range(3))
      0: return 0;
      1: return maxv;
      default: return $urandom_range(maxv);
    endcase
  endfunction

  // Favor values right at the threshold boundary.
  function automatic logic [7:0] pick_pixel(logic [7:0] thr);
    case ($urandom_range(4))
      0: return thr;
      1: return thr - 8'd1;
      2: return 8'hFF;
      3: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_altitude();
    case ($urandom_range(4))
      0: return 16'($urandom_range(200));
      1: return AltMin;
      2: return AltMin + 16'd1;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Hold start high until the word is taken; start stays high for a following word.
  task automatic send_pixel(input logic [7:0] pix, input logic [15:0] alt);
    start_i       <= 1'b1;
    pixel_value_i <= pix;
    altitude_mm_i <= alt;
    do @(posedge clk_i); while (busy_o);
    sb.note_pixel(pix, alt);
    items_sent++;
  endtask

  task automatic maybe_idle();
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_frames.size() != 0 || busy_o);
  endtask

  task automatic settle();
    drain();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [18:0] value);
    wr_en_i   <= 1'b1;
    wr_idx_i  <= idx;
    wr_data_i <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic apply_config(input logic [18:0] thr, input logic [18:0] minp,
                              input logic [18:0] cen_u, input logic [18:0] cen_v,
                              input logic [18:0] foc, input logic [18:0] full,
                              input logic [18:0] fw, input logic [18:0] fh);
    settle();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_MIN_PIX, minp);
    write_reg(REG_CENTER_U, cen_u);
    write_reg(REG_CENTER_V, cen_v);
    write_reg(REG_FOCAL, foc);
    write_reg(REG_FULL_CONF, full);
    write_reg(REG_WIDTH, fw);
    write_reg(REG_HEIGHT, fh);
    wr_en_i <= 1'b0;
  endtask

  initial begin
    int          base;
    int          phase;
    int          npix;
    int          frames_n;
    int unsigned wpix;
    int unsigned hpix;
    logic [7:0]  thr;
    logic [9:0]  fw;
    logic [9:0]  fh;
    logic [18:0] minp;
    logic [18:0] full;

    sb         = new();
    idle_pct   = 0;
    items_sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero frame size, zero minimum and zero divisors; every pixel is a frame.
    apply_config(19'd128, 19'd0, 19'd511, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0);
    send_pixel(8'd255, 16'd65535);
    send_pixel(8'd0, 16'd65535);
    send_pixel(8'd128, 16'd200);
    send_pixel(8'd127, 16'd201);
    send_pixel(8'd200, 16'd201);
    send_pixel(8'd255, 16'd0);

    // All pixels bright, widest focal length, lowest confidence clamp.
    apply_config(19'd0, 19'd6, 19'd0, 19'd0, 19'd4095, 19'h7FFFF, 19'd3, 19'd2);
    for (int i = 0; i < 6; i++)
      send_pixel(8'($urandom), (i == 5) ? 16'hFFFF : 16'($urandom));

    // Shrink width, then height, in the middle of a frame.
    apply_config(19'd255, 19'd1, 19'd1, 19'd1, 19'd64, 19'd1, 19'd4, 19'd4);
    repeat (6) send_pixel(8'd255, 16'd1000);
    settle();
    write_reg(REG_WIDTH, 19'd2);
    wr_en_i <= 1'b0;
    send_pixel(8'd255, 16'd1000);
    settle();
    write_reg(REG_HEIGHT, 19'd1);
    wr_en_i <= 1'b0;
    repeat (3) send_pixel(8'd255, 16'hFFFF);

    base  = items_sent;
    phase = 0;
    while (items_sent - base < RandomItems) begin
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 62;
        default: idle_pct = 14;
      endcase
      thr = 8'(pick_edge(255));
      // Keep frames small apart from one widest row and one tallest column.
      if (phase == 3) begin
        fw = 10'd1023;
        fh = 10'd1;
      end else if (phase == 6) begin
        fw = 10'd1;
        fh = 10'd512;
      end else begin
        fw = 10'($urandom_range(6));
        fh = 10'($urandom_range(6));
      end
      wpix = (fw == 0) ? 1 : ((fw > MaxWidth) ? MaxWidth : fw);
      hpix = (fh == 0) ? 1 : ((fh > MaxHeight) ? MaxHeight : fh);
      npix = wpix * hpix;
      case ($urandom_range(9))
        0: minp = 19'h7FFFF;
        1: minp = 19'd0;
        default: minp = 19'($urandom_range(npix + 1, 1));
      endcase
      case ($urandom_range(7))
        0: full = 19'd0;
        1: full = 19'h7FFFF;
        default: full = 19'($urandom_range(npix * 12, 1));
      endcase
      apply_config(19'(thr), minp, 19'(pick_edge(511)), 19'(pick_edge(511)),
                   19'(pick_edge(4095)), full, 19'(fw), 19'(fh));
      frames_n = (npix >= 60) ? 1 : 60 / npix;
      for (int f = 0; f < frames_n; f++) begin
        for (int p = 0; p < npix; p++) begin
          send_pixel(pick_pixel(thr), pick_altitude());
          maybe_idle();
        end
        if ($urandom_range(7) == 0) drain();
      end
      phase++;
    end

    settle();
    if (sb.mismatches == 0 && sb.pending_frames.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
